// ----- hw/rtl/euler_to_quaternion_top_defines.svh -----
// assertion macros for the euler to quaternion block
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define E2Q_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define E2Q_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

// ----- hw/rtl/e2q_pkg.sv -----
// types and constants for the euler to quaternion block
package e2q_pkg;
  localparam int WORK_FRAC = 30;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } e2q_out_t;

  typedef logic signed [33:0] trig_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2F;  10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
      15: a = 32'h0000517C; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A2F; 19: a = 32'h00000517; 20: a = 32'h0000028B;
      21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
      24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      27: a = 32'h00000005; 28: a = 32'h00000002; 29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return $signed({2'b00, a});
  endfunction
endpackage

// ----- hw/rtl/euler_to_quaternion_top.sv -----
// ZYX euler angles to quaternion: takes a word every cycle, busy stays low, and each
// result appears with out_valid for one cycle once it has passed the cordic stages, the
// product and sum stages and the output register
`include "euler_to_quaternion_top_defines.svh"
module euler_to_quaternion_top import e2q_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int QUAT_FRAC_BITS = 15,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  e2q_in_t  in_data,
  output logic     out_valid,
  output e2q_out_t out_data
);
  localparam int LAT = TRIG_ITERATIONS + 3;
  logic [LAT-1:0] vld_r, vld_nxt;
  e2q_out_t quat;
  e2q_out_t out_r;
  logic out_valid_r;
  trig_t cr, sr, cp, sp, cy, sy;

  assign busy = 1'b0;

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_roll (
    .clk(clk), .angle(in_data.roll_angle[ANGLE_BITS-1:0]), .cos_q(cr), .sin_q(sr));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_pitch (
    .clk(clk), .angle(in_data.pitch_angle[ANGLE_BITS-1:0]), .cos_q(cp), .sin_q(sp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_yaw (
    .clk(clk), .angle(in_data.yaw_angle[ANGLE_BITS-1:0]), .cos_q(cy), .sin_q(sy));

  e2q_combine #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_comb (
    .clk(clk), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy), .quat(quat));

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      out_valid_r <= vld_r[LAT-1];
    end
    out_r <= quat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `E2Q_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  `E2Q_ASSERT_NXT(a_valid_shift, clk, rst_n, vld_r[LAT-1], out_valid)
  `E2Q_ASSERT_NXT(a_start_tracked, clk, rst_n, start, vld_r[0])
endmodule

// ----- hw/rtl/e2q_cordic.sv -----
// pipelined rotation cordic, half-angle sine and cosine, one stage per step
module e2q_cordic import e2q_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] angle,
  output trig_t                 cos_q,
  output trig_t                 sin_q
);
  trig_t x_r [TRIG_ITERATIONS+1];
  trig_t y_r [TRIG_ITERATIONS+1];
  trig_t z_r [TRIG_ITERATIONS+1];
  logic [31:0] turn;

  assign turn = {angle, {(32-ANGLE_BITS){1'b0}}} >> 0;

  always_comb begin
    x_r[0] = CORDIC_GAIN_INV;
    y_r[0] = '0;
    z_r[0] = $signed({{3{turn[31]}}, turn[31:1]});
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_step
    trig_t x_nxt, y_nxt, z_nxt;
    always_comb begin
      if (!z_r[i][33]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_turn(i);
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_turn(i);
      end
    end
    always_ff @(posedge clk) begin
      x_r[i+1] <= x_nxt;
      y_r[i+1] <= y_nxt;
      z_r[i+1] <= z_nxt;
    end
  end

  assign cos_q = x_r[TRIG_ITERATIONS];
  assign sin_q = y_r[TRIG_ITERATIONS];
endmodule

// ----- hw/rtl/e2q_combine.sv -----
// triple products, sums and output rounding, three register stages
module e2q_combine import e2q_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic     clk,
  input  trig_t    cr, sr, cp, sp, cy, sy,
  output e2q_out_t quat
);
  localparam int OW = QUAT_FRAC_BITS + 1;
  typedef logic signed [35:0] prod_t;
  prod_t p_r [4];
  trig_t cy_r, sy_r;
  prod_t t_r [8];
  logic signed [37:0] s_r [4];

  function automatic prod_t q30(input trig_t a, input trig_t b);
    logic signed [67:0] m;
    m = a * b;
    return prod_t'(m >>> WORK_FRAC);
  endfunction

  function automatic logic [15:0] outq(input logic signed [37:0] v);
    logic signed [39:0] r;
    logic signed [39:0] lim;
    lim = (40'sd1 <<< QUAT_FRAC_BITS) - 40'sd1;
    if (QUAT_FRAC_BITS < WORK_FRAC)
      r = (40'(v) + (40'sd1 <<< (WORK_FRAC - QUAT_FRAC_BITS - 1)))
          >>> (WORK_FRAC - QUAT_FRAC_BITS);
    else
      r = 40'(v) <<< (QUAT_FRAC_BITS - WORK_FRAC);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return 16'(r[OW-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    p_r[0] <= q30(cr, cp);
    p_r[1] <= q30(sr, sp);
    p_r[2] <= q30(sr, cp);
    p_r[3] <= q30(cr, sp);
    cy_r   <= cy;
    sy_r   <= sy;
    t_r[0] <= q30(trig_t'(p_r[0]), cy_r);
    t_r[1] <= q30(trig_t'(p_r[1]), sy_r);
    t_r[2] <= q30(trig_t'(p_r[2]), cy_r);
    t_r[3] <= q30(trig_t'(p_r[3]), sy_r);
    t_r[4] <= q30(trig_t'(p_r[3]), cy_r);
    t_r[5] <= q30(trig_t'(p_r[2]), sy_r);
    t_r[6] <= q30(trig_t'(p_r[0]), sy_r);
    t_r[7] <= q30(trig_t'(p_r[1]), cy_r);
    s_r[0] <= 38'(t_r[0]) + 38'(t_r[1]);
    s_r[1] <= 38'(t_r[2]) - 38'(t_r[3]);
    s_r[2] <= 38'(t_r[4]) + 38'(t_r[5]);
    s_r[3] <= 38'(t_r[6]) - 38'(t_r[7]);
  end

  assign quat.quat_w = outq(s_r[0]);
  assign quat.quat_x = outq(s_r[1]);
  assign quat.quat_y = outq(s_r[2]);
  assign quat.quat_z = outq(s_r[3]);
endmodule

// ----- sim/tb_top.sv -----
// testbench for the euler angle to quaternion block: directed and random angle words
`timescale 1ns / 100ps
module tb_top;
  import e2q_pkg::*;

  localparam int LATENCY = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QLIM = 32767;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  e2q_in_t in_data = '0;
  logic out_valid;
  e2q_out_t out_data;

  e2q_out_t quat_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  logic burst_on = 1'b1;
  int burst_left = 0;

  euler_to_quaternion_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  task automatic half_trig(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy, a;
    logic signed [31:0] turn;
    turn = {ang, 16'h0};
    z = floor_shr(longint'(turn), 1);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      a = atan_table(i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    c = x;
    s = y;
  endtask

  function automatic longint atan_table(int i);
    longint t[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
    return t[i];
  endfunction

  function automatic longint triple(longint a, longint b, longint c);
    return floor_shr(floor_shr(a * b, 30) * c, 30);
  endfunction

  function automatic logic [15:0] to_q15(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 14), 15);
    if (r > QLIM) r = QLIM;
    if (r < -QLIM) r = -QLIM;
    return r[15:0];
  endfunction

  task automatic predict_quat(input e2q_in_t a, output e2q_out_t q);
    longint cr, sr, cp, sp, cy, sy;
    half_trig(a.roll_angle, cr, sr);
    half_trig(a.pitch_angle, cp, sp);
    half_trig(a.yaw_angle, cy, sy);
    q.quat_w = to_q15(triple(cr, cp, cy) + triple(sr, sp, sy));
    q.quat_x = to_q15(triple(sr, cp, cy) - triple(cr, sp, sy));
    q.quat_y = to_q15(triple(cr, sp, cy) + triple(sr, cp, sy));
    q.quat_z = to_q15(triple(cr, cp, sy) - triple(sr, sp, cy));
  endtask

  task automatic send_angles(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y);
    e2q_out_t q;
    e2q_in_t w;
    while (!burst_on) begin
      start <= 1'b0;
      @(posedge clk);
    end
    w.roll_angle = r;
    w.pitch_angle = p;
    w.yaw_angle = y;
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_quat(w, q);
    quat_queue.push_back(q);
  endtask

  // burst pattern of the sender, toggled each time its counter runs out
  always @(posedge clk) begin
    if (burst_left == 0) begin
      burst_on <= !burst_on;
      burst_left <= burst_on ? $urandom_range(0, 6) : $urandom_range(1, 40);
    end else begin
      burst_left <= burst_left - 1;
    end
  end

  always @(posedge clk) begin
    e2q_out_t q;
    if (start && !busy || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid) begin
      if (quat_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        q = quat_queue.pop_front();
        if (q !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp w %h x %h y %h z %h got w %h x %h y %h z %h",
                     q.quat_w, q.quat_x, q.quat_y, q.quat_z, out_data.quat_w,
                     out_data.quat_x, out_data.quat_y, out_data.quat_z);
        end
      end
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic test_extremes();
    logic [15:0] v[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
    for (int i = 0; i < 6; i++) send_angles(v[i], v[i], v[i]);
    send_angles(16'h8000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h8000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h8000);
    send_angles(16'h7FFF, 16'h8000, 16'h7FFF);
    send_angles(16'h8000, 16'h7FFF, 16'h8000);
    send_angles(16'h0001, 16'hFFFF, 16'h5555);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_random();
    logic [15:0] a[3];
    for (int n = 0; n < 1600; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 4))
          0: a[k] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          1: a[k] = 16'($urandom_range(0, 15) - 8);
          default: a[k] = 16'($urandom);
        endcase
      end
      send_angles(a[0], a[1], a[2]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random();
    start <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
